// ===== src/ffa_pkg.sv =====
package ffa_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SZ_W = 17;
  localparam int REQ_W = 14;
  localparam int FIELD_W = 14;

  localparam int DEF_NUM_BLOCKS = 10;
  localparam int DEF_POOL_BYTES = 16384;
  localparam int DEF_HEADER_BYTES = 16;

  localparam int FIXED_SIZES [MAX_SLOTS] = '{
    1600, 1500, 1400, 1700, 1700, 1800, 2000, 1700, 1400,
    0, 0, 0, 0, 0, 0, 0
  };

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FREED   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  // control handed from the top level to every cell
  typedef struct packed {
    logic update;
    logic op_free;
  } cell_ctrl_t;

  // usable size of each block, packed SZ_W bits per block
  function automatic logic [MAX_SLOTS*SZ_W-1:0] size_table(int nblk, int pool, int hdr);
    logic [MAX_SLOTS*SZ_W-1:0] t;
    int pos;
    int sz;
    int used;
    t = '0;
    pos = 0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (i < nblk) begin
        if (i + 1 < nblk) begin
          sz = FIXED_SIZES[i];
        end else begin
          used = pos + hdr;
          sz = (pool > used) ? pool - used : 0;
        end
        t[i*SZ_W +: SZ_W] = SZ_W'(sz);
        pos = pos + sz + hdr;
      end
    end
    return t;
  endfunction

  // header offset of each block, packed SZ_W bits per block
  function automatic logic [MAX_SLOTS*SZ_W-1:0] offset_table(int nblk, int pool, int hdr);
    logic [MAX_SLOTS*SZ_W-1:0] t;
    int pos;
    int sz;
    int used;
    t = '0;
    pos = 0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (i < nblk) begin
        if (i + 1 < nblk) begin
          sz = FIXED_SIZES[i];
        end else begin
          used = pos + hdr;
          sz = (pool > used) ? pool - used : 0;
        end
        t[i*SZ_W +: SZ_W] = SZ_W'(pos);
        pos = pos + sz + hdr;
      end
    end
    return t;
  endfunction

endpackage

// ===== src/ffa_if.sv =====
interface ffa_in_if;
  logic                         valid;
  logic                         ready;
  ffa_pkg::op_t                 op;
  logic [ffa_pkg::REQ_W-1:0]    request_bytes;
  logic [ffa_pkg::FIELD_W-1:0]  free_offset;

  modport source (output valid, output op, output request_bytes, output free_offset,
                  input ready);
  modport sink   (input valid, input op, input request_bytes, input free_offset,
                  output ready);
endinterface

interface ffa_out_if;
  logic                         valid;
  logic                         ready;
  ffa_pkg::status_t             status;
  logic [ffa_pkg::FIELD_W-1:0]  block_offset;
  logic [ffa_pkg::FIELD_W-1:0]  block_bytes;

  modport source (output valid, output status, output block_offset, output block_bytes,
                  input ready);
  modport sink   (input valid, input status, input block_offset, input block_bytes,
                  output ready);
endinterface

// ===== src/first_fit_block_allocator_top.sv =====
// First-fit allocator over a pool of NUM_BLOCKS fixed blocks. An allocate
// transaction returns the header offset and usable size of the first block
// on the free list that holds the request, or no fit; a free transaction
// returns a block to the front of the list, and is refused for an address
// that is not a block header or for a block that is already free. A
// transaction is first captured; then the row of list cells compares
// every entry against the request and shifts the list.
// The result sits in an output register; the next transaction is taken
// while it waits, but its list update waits until that result is taken.
module first_fit_block_allocator_top #(
  parameter int NUM_BLOCKS = ffa_pkg::DEF_NUM_BLOCKS,
  parameter int POOL_BYTES = ffa_pkg::DEF_POOL_BYTES,
  parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  ffa_in_if.sink    in_ch,
  ffa_out_if.source out_ch
);

  localparam int IDW = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int SW = ffa_pkg::SZ_W;
  localparam logic [ffa_pkg::MAX_SLOTS*SW-1:0] SIZES =
    ffa_pkg::size_table(NUM_BLOCKS, POOL_BYTES, HEADER_BYTES);
  localparam logic [ffa_pkg::MAX_SLOTS*SW-1:0] OFFS =
    ffa_pkg::offset_table(NUM_BLOCKS, POOL_BYTES, HEADER_BYTES);

  logic                          busy_r;
  ffa_pkg::op_t                  op_r;
  logic [ffa_pkg::REQ_W-1:0]     req_r;
  logic [ffa_pkg::FIELD_W-1:0]   foff_r;
  logic [CW-1:0]                 count_r;
  logic [NUM_BLOCKS-1:0]         in_use_r;
  logic                          out_valid_r;
  ffa_pkg::status_t              out_status_r;
  logic [ffa_pkg::FIELD_W-1:0]   out_off_r;
  logic [ffa_pkg::FIELD_W-1:0]   out_bytes_r;

  logic                          step;
  logic                          is_free;
  ffa_pkg::cell_ctrl_t           ctrl;
  logic [NUM_BLOCKS:0]           hit_chain;
  logic [IDW-1:0]                entries [NUM_BLOCKS];
  logic [IDW-1:0]                sels [NUM_BLOCKS];
  logic [IDW-1:0]                hit_blk;
  logic                          any_hit;
  logic [NUM_BLOCKS-1:0]         match;
  logic [IDW-1:0]                match_blk;
  logic                          free_ok;

  assign step    = busy_r && (!out_valid_r || out_ch.ready);
  assign is_free = (op_r == ffa_pkg::OP_FREE);
  assign any_hit = hit_chain[NUM_BLOCKS];
  assign hit_chain[0] = 1'b0;

  always_comb begin
    hit_blk   = '0;
    match     = '0;
    match_blk = '0;
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      hit_blk  = hit_blk | sels[k];
      match[k] = (OFFS[k*SW +: SW] == SW'(foff_r));
      if (match[k]) begin
        match_blk = match_blk | IDW'(k);
      end
    end
  end

  assign free_ok     = (|match) && in_use_r[match_blk];
  assign ctrl.update = step && (is_free ? free_ok : any_hit);
  assign ctrl.op_free = is_free;

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    ffa_cell #(
      .IDX(g),
      .NUM_BLOCKS(NUM_BLOCKS),
      .POOL_BYTES(POOL_BYTES),
      .HEADER_BYTES(HEADER_BYTES),
      .IDW(IDW)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .ctrl(ctrl),
      .valid(CW'(g) < count_r),
      .req(req_r),
      .hit_in(hit_chain[g]),
      .prev_entry(entries[(g == 0) ? 0 : g - 1]),
      .next_entry(entries[(g == NUM_BLOCKS - 1) ? g : g + 1]),
      .push_blk(match_blk),
      .hit_out(hit_chain[g+1]),
      .entry(entries[g]),
      .sel_entry(sels[g])
    );
  end

  assign in_ch.ready         = !busy_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.block_offset = out_off_r;
  assign out_ch.block_bytes  = out_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= CW'(NUM_BLOCKS);
      in_use_r    <= '0;
    end else begin
      if (in_ch.valid && !busy_r) begin
        busy_r <= 1'b1;
      end else if (step) begin
        busy_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.update) begin
        if (is_free) begin
          count_r             <= count_r + CW'(1);
          in_use_r[match_blk] <= 1'b0;
        end else begin
          count_r           <= count_r - CW'(1);
          in_use_r[hit_blk] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && !busy_r) begin
      op_r   <= in_ch.op;
      req_r  <= in_ch.request_bytes;
      foff_r <= in_ch.free_offset;
    end
    if (step) begin
      if (is_free) begin
        out_status_r <= free_ok ? ffa_pkg::ST_FREED : ffa_pkg::ST_REFUSED;
        out_off_r    <= free_ok ? OFFS[32'(match_blk)*SW +: ffa_pkg::FIELD_W] : '0;
        out_bytes_r  <= free_ok ? SIZES[32'(match_blk)*SW +: ffa_pkg::FIELD_W] : '0;
      end else begin
        out_status_r <= any_hit ? ffa_pkg::ST_ALLOC : ffa_pkg::ST_NOFIT;
        out_off_r    <= any_hit ? OFFS[32'(hit_blk)*SW +: ffa_pkg::FIELD_W] : '0;
        out_bytes_r  <= any_hit ? SIZES[32'(hit_blk)*SW +: ffa_pkg::FIELD_W] : '0;
      end
    end
  end

endmodule

// ===== src/ffa_cell.sv =====
module ffa_cell #(
  parameter int IDX = 0,
  parameter int NUM_BLOCKS = ffa_pkg::DEF_NUM_BLOCKS,
  parameter int POOL_BYTES = ffa_pkg::DEF_POOL_BYTES,
  parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES,
  parameter int IDW = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ffa_pkg::cell_ctrl_t       ctrl,
  input  logic                      valid,
  input  logic [ffa_pkg::REQ_W-1:0] req,
  input  logic                      hit_in,
  input  logic [IDW-1:0]            prev_entry,
  input  logic [IDW-1:0]            next_entry,
  input  logic [IDW-1:0]            push_blk,
  output logic                      hit_out,
  output logic [IDW-1:0]            entry,
  output logic [IDW-1:0]            sel_entry
);

  localparam logic [ffa_pkg::MAX_SLOTS*ffa_pkg::SZ_W-1:0] SIZES =
    ffa_pkg::size_table(NUM_BLOCKS, POOL_BYTES, HEADER_BYTES);

  logic [IDW-1:0]           entry_r;
  logic [IDW-1:0]           entry_nxt;
  logic [ffa_pkg::SZ_W-1:0] my_size;
  logic                     my_hit;

  assign my_size   = SIZES[32'(entry_r) * ffa_pkg::SZ_W +: ffa_pkg::SZ_W];
  assign my_hit    = valid && (my_size >= ffa_pkg::SZ_W'(req));
  assign hit_out   = hit_in | my_hit;
  assign entry     = entry_r;
  // only the first fitting cell reports its block
  assign sel_entry = (my_hit && !hit_in) ? entry_r : '0;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.update) begin
      if (ctrl.op_free) begin
        entry_nxt = (IDX == 0) ? push_blk : prev_entry;
      end else if (hit_out) begin
        // close the gap at and after the taken slot
        entry_nxt = next_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= IDW'(IDX);
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// ===== src/ffa_checker.sv =====
module ffa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input ffa_pkg::status_t            out_status,
  input logic [ffa_pkg::FIELD_W-1:0] out_block_offset,
  input logic [ffa_pkg::FIELD_W-1:0] out_block_bytes
);

  // a failed transaction reports an empty block
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ffa_pkg::ST_NOFIT || out_status == ffa_pkg::ST_REFUSED)
    |-> out_block_offset == '0 && out_block_bytes == '0)
    else $error("failed transaction with nonzero block fields");

  // input ready drops once a transaction is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a result appears only after an input was taken
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a pending transaction");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_block_offset) && $stable(out_block_bytes))
    else $error("stalled result changed");

endmodule

bind first_fit_block_allocator_top ffa_checker u_ffa_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_status(out_ch.status),
  .out_block_offset(out_ch.block_offset),
  .out_block_bytes(out_ch.block_bytes)
);

// ===== tb/sv/tb_first_fit_block_allocator_top.sv =====
`timescale 1ns / 100ps

module tb_first_fit_block_allocator_top;
  import ffa_pkg::*;

  localparam int BLOCK_COUNT = 10;
  localparam int POOL_SIZE = 16384;
  localparam int HDR_SIZE = 16;
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_ITEMS = 60;
  localparam int LONG_HOLD = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    op_t                 op;
    logic [REQ_W-1:0]    request_bytes;
    logic [FIELD_W-1:0]  free_offset;
    bit                  wait_drain;
  } pool_req_t;

  typedef struct {
    status_t             status;
    logic [FIELD_W-1:0]  block_offset;
    logic [FIELD_W-1:0]  block_bytes;
  } pool_resp_t;

  logic clk;
  logic rst_n;

  ffa_in_if  in_ch();
  ffa_out_if out_ch();

  first_fit_block_allocator_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // block map and allocator state as the block should hold it
  int unsigned        fixed_bytes [BLOCK_COUNT-1] = '{1600, 1500, 1400, 1700, 1700, 1800,
                                                      2000, 1700, 1400};
  logic [FIELD_W-1:0] hdr_offset [BLOCK_COUNT];
  logic [FIELD_W-1:0] usable_bytes [BLOCK_COUNT];
  int                 open_blocks [$];
  bit                 block_taken [BLOCK_COUNT];

  pool_req_t  req_backlog [$];
  pool_resp_t resp_expected [$];
  pool_req_t  req_on_bus;

  int  fault_count = 0;
  int  sent_count = 0;
  int  got_count = 0;
  int  send_gap = 0;
  int  sink_hold = 0;
  int  quiet_cycles = 0;
  bit  long_hold_done = 0;
  bit  tail_phase = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.free_offset = '0;
    out_ch.ready = 1'b0;
  end

  // last block takes whatever the fixed blocks leave of the pool
  function automatic void build_block_map();
    int pos;
    int sz;
    pos = 0;
    for (int b = 0; b < BLOCK_COUNT; b++) begin
      if (b + 1 < BLOCK_COUNT) begin
        sz = fixed_bytes[b];
      end else begin
        sz = (POOL_SIZE > pos + HDR_SIZE) ? POOL_SIZE - pos - HDR_SIZE : 0;
      end
      hdr_offset[b] = FIELD_W'(pos);
      usable_bytes[b] = FIELD_W'(sz);
      pos = pos + sz + HDR_SIZE;
    end
    open_blocks.delete();
    for (int b = 0; b < BLOCK_COUNT; b++) begin
      open_blocks.push_back(b);
      block_taken[b] = 1'b0;
    end
  endfunction

  function automatic pool_resp_t apply_pool_request(pool_req_t it);
    pool_resp_t r;
    int pos;
    int blk;
    r.block_offset = '0;
    r.block_bytes = '0;
    pos = -1;
    blk = -1;
    if (it.op == OP_ALLOC) begin
      r.status = ST_NOFIT;
      foreach (open_blocks[i]) begin
        if (pos < 0 && usable_bytes[open_blocks[i]] >= it.request_bytes) pos = i;
      end
      if (pos >= 0) begin
        blk = open_blocks[pos];
        open_blocks.delete(pos);
        block_taken[blk] = 1'b1;
        r.status = ST_ALLOC;
        r.block_offset = hdr_offset[blk];
        r.block_bytes = usable_bytes[blk];
      end
    end else begin
      r.status = ST_REFUSED;
      for (int b = 0; b < BLOCK_COUNT; b++) begin
        if (blk < 0 && hdr_offset[b] == it.free_offset) blk = b;
      end
      // refused for a non-header address or a block that is already free
      if (blk >= 0 && block_taken[blk]) begin
        open_blocks.push_front(blk);
        block_taken[blk] = 1'b0;
        r.status = ST_FREED;
        r.block_offset = hdr_offset[blk];
        r.block_bytes = usable_bytes[blk];
      end
    end
    return r;
  endfunction

  function automatic void queue_req(op_t op, int req, int off, bit drain);
    pool_req_t it;
    it.op = op;
    it.request_bytes = (op == OP_ALLOC) ? REQ_W'(req) : REQ_W'($urandom_range(0, 16368));
    it.free_offset = (op == OP_FREE) ? FIELD_W'(off) : FIELD_W'($urandom_range(0, 16383));
    it.wait_drain = drain;
    req_backlog.push_back(it);
  endfunction

  function automatic void build_directed();
    queue_req(OP_ALLOC, 0, 0, 0);         // zero request, first listed block
    queue_req(OP_ALLOC, 16368, 0, 0);     // largest request, no fit
    queue_req(OP_ALLOC, 2000, 0, 0);      // only the largest block fits
    queue_req(OP_ALLOC, 2000, 0, 0);
    queue_req(OP_ALLOC, 1601, 0, 0);
    queue_req(OP_FREE, 0, 0, 0);
    queue_req(OP_FREE, 0, 0, 0);          // double free
    queue_req(OP_FREE, 0, 1616, 0);       // never allocated
    queue_req(OP_FREE, 0, 16383, 0);      // not a header
    queue_req(OP_FREE, 0, 1617, 0);
    queue_req(OP_ALLOC, 1401, 0, 0);
    queue_req(OP_ALLOC, 1, 0, 0);
    queue_req(OP_ALLOC, 1425, 0, 0);
    repeat (5) queue_req(OP_ALLOC, 0, 0, 0);
    queue_req(OP_ALLOC, 0, 0, 0);         // empty list
    queue_req(OP_FREE, 0, 14944, 0);
    queue_req(OP_ALLOC, 1425, 0, 0);      // one byte over the remainder block
    queue_req(OP_ALLOC, 1424, 0, 0);
    queue_req(OP_FREE, 0, 13528, 0);
    queue_req(OP_FREE, 0, 9796, 0);
    queue_req(OP_ALLOC, 1500, 0, 0);
  endfunction

  function automatic void build_random();
    int req;
    int off;
    int pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 45) begin
        off = hdr_offset[$urandom_range(0, BLOCK_COUNT - 1)];
        if (pick >= 90) off = $urandom_range(0, 16383);
        else if (pick >= 80) off = (off == 0) ? 1 : off + ($urandom_range(0, 1) ? 1 : -1);
        queue_req(OP_FREE, 0, off, (n == 0) || ($urandom_range(0, 99) == 0));
      end else begin
        if (pick < 75) req = $urandom_range(0, 2000);
        else if (pick < 90) req = $urandom_range(1390, 2010);
        else req = $urandom_range(0, 16368);
        queue_req(OP_ALLOC, req, 0, (n == 0) || ($urandom_range(0, 99) == 0));
      end
    end
  endfunction

  always @(posedge clk) begin : drive_proc
    pool_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        resp_expected.push_back(apply_pool_request(req_on_bus));
        sent_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (req_backlog.size() == 0 ||
                     (req_backlog[0].wait_drain && resp_expected.size() != 0)) begin
          in_ch.valid <= 1'b0;
        end else begin
          nxt = req_backlog.pop_front();
          req_on_bus = nxt;
          in_ch.valid <= 1'b1;
          in_ch.op <= nxt.op;
          in_ch.request_bytes <= nxt.request_bytes;
          in_ch.free_offset <= nxt.free_offset;
          if (req_backlog.size() < TAIL_ITEMS) tail_phase = 1'b1;
          // idle bursts only in some windows of the run
          if (!tail_phase && (sent_count / 64) % 3 != 2 && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 11);
        end
      end
    end
  end

  always @(posedge clk) begin : collect_proc
    pool_resp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_count++;
        if (resp_expected.size() == 0) begin
          $error("unexpected transaction: status %0d offset %0d bytes %0d",
                 out_ch.status, out_ch.block_offset, out_ch.block_bytes);
          fault_count++;
        end else begin
          want = resp_expected.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            fault_count++;
          end
          if (out_ch.block_offset !== want.block_offset) begin
            $error("block_offset: expected %0d, got %0d", want.block_offset,
                   out_ch.block_offset);
            fault_count++;
          end
          if (out_ch.block_bytes !== want.block_bytes) begin
            $error("block_bytes: expected %0d, got %0d", want.block_bytes,
                   out_ch.block_bytes);
            fault_count++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && got_count >= 150) begin
        // long hold-off so the block backs up and stalls its input
        long_hold_done = 1'b1;
        sink_hold = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (!tail_phase && (got_count / 50) % 3 != 1 && $urandom_range(0, 7) == 0) begin
        sink_hold = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_first_fit_block_allocator_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    build_block_map();
    build_directed();
    build_random();
    build_block_map();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (req_backlog.size() != 0 || in_ch.valid || resp_expected.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_first_fit_block_allocator_top: clean");
    end else begin
      $display("tb_first_fit_block_allocator_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ffa_pkg.sv
src/ffa_if.sv
src/ffa_cell.sv
src/first_fit_block_allocator_top.sv
src/ffa_checker.sv
tb/sv/tb_first_fit_block_allocator_top.sv
